[hw/rtl/xxh32_pkg.sv]
// Shared constants, microcode format and program ROM of the xxHash32 short-path engine.
package xxh32_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned PC_W    = 4;

    localparam logic [WORD_W-1:0] PRIME1 = 32'd2654435761;
    localparam logic [WORD_W-1:0] PRIME2 = 32'd2246822519;
    localparam logic [WORD_W-1:0] PRIME3 = 32'd3266489917;
    localparam logic [WORD_W-1:0] PRIME4 = 32'd668265263;
    localparam logic [WORD_W-1:0] PRIME5 = 32'd374761393;

    // multiplier operand A select
    localparam logic [2:0] A_WORD  = 3'd0;
    localparam logic [2:0] A_BYTE  = 3'd1;
    localparam logic [2:0] A_ROT17 = 3'd2;
    localparam logic [2:0] A_ROT11 = 3'd3;
    localparam logic [2:0] A_AV15  = 3'd4;
    localparam logic [2:0] A_AV13  = 3'd5;

    // multiplier constant select
    localparam logic [2:0] K_P1 = 3'd0;
    localparam logic [2:0] K_P2 = 3'd1;
    localparam logic [2:0] K_P3 = 3'd2;
    localparam logic [2:0] K_P4 = 3'd3;
    localparam logic [2:0] K_P5 = 3'd4;

    // accumulator operation
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_ADD  = 2'd1;
    localparam logic [1:0] ACC_PROD = 2'd2;

    // sequencing
    localparam logic [1:0] SEQ_NEXT = 2'd0;
    localparam logic [1:0] SEQ_WEND = 2'd1;  // last item: jump to target, else stop
    localparam logic [1:0] SEQ_LOOP = 2'd2;  // more tail bytes: jump to target, else fall through
    localparam logic [1:0] SEQ_DONE = 2'd3;  // emit result and stop

    // program addresses
    localparam logic [PC_W-1:0] PC_W0 = 4'd0;
    localparam logic [PC_W-1:0] PC_W1 = 4'd1;
    localparam logic [PC_W-1:0] PC_W2 = 4'd2;
    localparam logic [PC_W-1:0] PC_W3 = 4'd3;
    localparam logic [PC_W-1:0] PC_B0 = 4'd4;
    localparam logic [PC_W-1:0] PC_B1 = 4'd5;
    localparam logic [PC_W-1:0] PC_B2 = 4'd6;
    localparam logic [PC_W-1:0] PC_B3 = 4'd7;
    localparam logic [PC_W-1:0] PC_A0 = 4'd8;
    localparam logic [PC_W-1:0] PC_A1 = 4'd9;
    localparam logic [PC_W-1:0] PC_A2 = 4'd10;

    typedef struct packed {
        logic            prod_load;
        logic [2:0]      a_sel;
        logic [2:0]      k_sel;
        logic [1:0]      acc_op;
        logic            idx_inc;
        logic [1:0]      seq;
        logic [PC_W-1:0] target;
    } t_ucode;

    typedef struct packed {
        logic            start;
        logic [PC_W-1:0] start_pc;
        logic            last;
        logic            more_bytes;
        logic            out_free;
    } t_seq_stat;

    function automatic logic [WORD_W-1:0] prime(input logic [2:0] sel);
        logic [WORD_W-1:0] k;
        unique case (sel)
            K_P1:    k = PRIME1;
            K_P2:    k = PRIME2;
            K_P3:    k = PRIME3;
            K_P4:    k = PRIME4;
            K_P5:    k = PRIME5;
            default: k = PRIME1;
        endcase
        return k;
    endfunction

    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode u;
        //            prod  a_sel    k_sel  acc_op    inc   seq       target
        unique case (pc)
            PC_W0:   u = '{1'b1, A_WORD,  K_P3, ACC_HOLD, 1'b0, SEQ_NEXT, PC_W0};
            PC_W1:   u = '{1'b0, A_WORD,  K_P3, ACC_ADD,  1'b0, SEQ_NEXT, PC_W0};
            PC_W2:   u = '{1'b1, A_ROT17, K_P4, ACC_HOLD, 1'b0, SEQ_NEXT, PC_W0};
            PC_W3:   u = '{1'b0, A_WORD,  K_P4, ACC_PROD, 1'b0, SEQ_WEND, PC_A0};
            PC_B0:   u = '{1'b1, A_BYTE,  K_P5, ACC_HOLD, 1'b0, SEQ_NEXT, PC_W0};
            PC_B1:   u = '{1'b0, A_BYTE,  K_P5, ACC_ADD,  1'b0, SEQ_NEXT, PC_W0};
            PC_B2:   u = '{1'b1, A_ROT11, K_P1, ACC_HOLD, 1'b0, SEQ_NEXT, PC_W0};
            PC_B3:   u = '{1'b0, A_WORD,  K_P1, ACC_PROD, 1'b1, SEQ_LOOP, PC_B0};
            PC_A0:   u = '{1'b1, A_AV15,  K_P2, ACC_HOLD, 1'b0, SEQ_NEXT, PC_W0};
            PC_A1:   u = '{1'b1, A_AV13,  K_P3, ACC_HOLD, 1'b0, SEQ_NEXT, PC_W0};
            PC_A2:   u = '{1'b0, A_WORD,  K_P1, ACC_HOLD, 1'b0, SEQ_DONE, PC_W0};
            default: u = '{1'b0, A_WORD,  K_P1, ACC_HOLD, 1'b0, SEQ_WEND, PC_A0};
        endcase
        return u;
    endfunction

endpackage

[hw/rtl/xxh32_seq.sv]
// Microcode sequencer: step counter, program ROM and jump logic.
module xxh32_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  xxh32_pkg::t_seq_stat     i_stat,
    output xxh32_pkg::t_ucode        o_ctl,
    output logic                     o_fire,
    output logic                     o_busy
);

    logic [xxh32_pkg::PC_W-1:0] r_pc;
    logic [xxh32_pkg::PC_W-1:0] n_pc;
    logic                       r_busy;
    logic                       n_busy;
    xxh32_pkg::t_ucode          ctl;
    logic                       fire;

    assign ctl  = xxh32_pkg::ucode_rom(r_pc);
    // the emit step waits for room in the output register
    assign fire = r_busy && ((ctl.seq != xxh32_pkg::SEQ_DONE) || i_stat.out_free);

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_stat.start) begin
            n_pc   = i_stat.start_pc;
            n_busy = 1'b1;
        end else if (fire) begin
            unique case (ctl.seq)
                xxh32_pkg::SEQ_NEXT: n_pc = r_pc + 1'b1;
                xxh32_pkg::SEQ_WEND: begin
                    if (i_stat.last) begin
                        n_pc = ctl.target;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                xxh32_pkg::SEQ_LOOP: n_pc = i_stat.more_bytes ? ctl.target : r_pc + 1'b1;
                xxh32_pkg::SEQ_DONE: n_busy = 1'b0;
                default:             n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= xxh32_pkg::PC_W0;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_ctl  = ctl;
    assign o_fire = fire;
    assign o_busy = r_busy;

`ifndef SYNTHESIS
    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= xxh32_pkg::PC_A2))
        else $error("sequencer left the program");

    a_no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.start |-> !r_busy)
        else $error("new item started while a program runs");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ctl.seq == xxh32_pkg::SEQ_DONE && !i_stat.start) |=> !r_busy)
        else $error("sequencer kept running after emit");
`endif

endmodule

[hw/rtl/xxh32_short_path_engine_top.sv]
// Top level of the xxHash32 short-path engine: handshakes, datapath and sequencer.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+----------------------------------------
//  in       | sink      | i_in_valid / o_in_stall   | i_data_word, i_byte_count,
//           |           |                           | i_first_item, i_last_item,
//           |           |                           | i_message_length
//  out      | source    | o_out_valid / i_out_stall | o_hash_value
//
//  A transaction on the input runs a short microprogram on one shared 32x32 multiplier
//  (low half kept, product registered). A non-last item runs a word round; a last item
//  runs a word round, its tail bytes or neither, and then the avalanche, so o_in_stall
//  stays high while that program runs. One item is in flight at a time, and the next
//  transaction is accepted only once the sequencer is idle again.
//  The result sits in an output register; the next item is taken while it waits, and
//  only the emit step of a following message holds on a stalled output.
//  Synchronous active-low reset clears the sequencer, the open-message flag, the running
//  hash and the output valid; items with no open message and no first flag are dropped.
module xxhash32_short_path_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_first_item,
    input  logic        i_last_item,
    input  logic [31:0] i_message_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    xxh32_pkg::t_ucode    ctl;
    xxh32_pkg::t_seq_stat stat;
    logic                 fire;
    logic                 busy;

    logic        in_acc;
    logic        take;
    logic [31:0] r_word;
    logic [1:0]  r_cnt;
    logic [1:0]  r_idx;
    logic        r_last;
    logic        r_open;
    logic [31:0] r_acc;
    logic [31:0] r_prod;
    logic [31:0] r_out;
    logic        r_out_valid;
    logic [31:0] mul_a;
    logic [31:0] mul_k;
    logic [31:0] byte_val;
    logic [2:0]  idx_next;

    // accept a transaction only when the sequencer is idle
    assign o_in_stall = busy;
    assign in_acc     = i_in_valid && !busy;
    // drop items that neither start a message nor continue an open one
    assign take       = in_acc && (i_first_item || r_open);

    // pick the entry point of the program
    always_comb begin
        stat.start      = take;
        stat.start_pc   = xxh32_pkg::PC_W0;
        if (i_last_item && !i_byte_count[2]) begin
            stat.start_pc = (i_byte_count[1:0] == 2'd0) ? xxh32_pkg::PC_A0 : xxh32_pkg::PC_B0;
        end
        stat.last       = r_last;
        stat.more_bytes = idx_next < {1'b0, r_cnt};
        stat.out_free   = !r_out_valid || !i_out_stall;
    end

    assign idx_next = {1'b0, r_idx} + 3'd1;

    xxh32_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_fire  (fire),
        .o_busy  (busy)
    );

    // tail byte, lowest address first
    always_comb begin
        case (r_idx)
            2'd0:    byte_val = {24'd0, r_word[7:0]};
            2'd1:    byte_val = {24'd0, r_word[15:8]};
            2'd2:    byte_val = {24'd0, r_word[23:16]};
            default: byte_val = {24'd0, r_word[31:24]};
        endcase
    end

    // multiplier operand; rotates act on the freshly summed accumulator
    always_comb begin
        unique case (ctl.a_sel)
            xxh32_pkg::A_WORD:  mul_a = r_word;
            xxh32_pkg::A_BYTE:  mul_a = byte_val;
            xxh32_pkg::A_ROT17: mul_a = {r_acc[14:0], r_acc[31:15]};
            xxh32_pkg::A_ROT11: mul_a = {r_acc[20:0], r_acc[31:21]};
            xxh32_pkg::A_AV15:  mul_a = r_acc ^ {15'd0, r_acc[31:15]};
            xxh32_pkg::A_AV13:  mul_a = r_prod ^ {13'd0, r_prod[31:13]};
            default:            mul_a = r_word;
        endcase
    end

    assign mul_k = xxh32_pkg::prime(ctl.k_sel);

    // item registers: latch payload on a taken transaction
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= i_data_word;
            r_cnt  <= i_byte_count[1:0];
            r_last <= i_last_item;
        end
    end

    // product register of the shared multiplier
    always_ff @(posedge i_clk) begin
        if (fire && ctl.prod_load) begin
            r_prod <= mul_a * mul_k;
        end
    end

    // tail byte index: clear on start, advance after each byte round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= 2'd0;
        end else if (fire && ctl.idx_inc) begin
            r_idx <= idx_next[1:0];
        end
    end

    // running hash and open-message flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= 32'd0;
            r_open <= 1'b0;
        end else begin
            if (take) begin
                r_open <= !i_last_item;
            end
            if (in_acc && i_first_item) begin
                r_acc <= xxh32_pkg::PRIME5 + i_message_length;
            end else if (fire) begin
                case (ctl.acc_op)
                    xxh32_pkg::ACC_ADD:  r_acc <= r_acc + r_prod;
                    xxh32_pkg::ACC_PROD: r_acc <= r_prod;
                    default:             r_acc <= r_acc;
                endcase
            end
        end
    end

    // output register: load on the emit step, drop on a delivered transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && ctl.seq == xxh32_pkg::SEQ_DONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && ctl.seq == xxh32_pkg::SEQ_DONE) begin
            r_out <= r_prod ^ {16'd0, r_prod[31:16]};
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out;

`ifndef SYNTHESIS
    a_byte_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && ctl.a_sel == xxh32_pkg::A_BYTE) |-> ({1'b0, r_idx} < {1'b0, r_cnt}))
        else $error("tail byte index beyond byte count");

    a_emit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ctl.seq == xxh32_pkg::SEQ_DONE) |-> (!r_open && r_last))
        else $error("hash emitted for a message still open");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(fire && ctl.seq == xxh32_pkg::SEQ_DONE))
        else $error("output valid without an emit step");

    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ctl.seq == xxh32_pkg::SEQ_DONE) |-> (!r_out_valid || !i_out_stall))
        else $error("emit overwrote a stalled result");
`endif

endmodule
